/* rtl/pls_pkg.sv */
// shared types, constants and codes for the positional list store
`timescale 1ns / 1ps
package pls_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_TAIL  = 3'd1;
	localparam logic [2:0] KIND_INSERT     = 3'd2;
	localparam logic [2:0] KIND_ERASE      = 3'd3;
	localparam logic [2:0] KIND_DUMP       = 3'd4;

	localparam logic [2:0] STAT_OK           = 3'd0;
	localparam logic [2:0] STAT_APPENDED     = 3'd1;
	localparam logic [2:0] STAT_TAIL_REMOVED = 3'd2;
	localparam logic [2:0] STAT_EMPTY        = 3'd3;
	localparam logic [2:0] STAT_FULL         = 3'd4;

	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_INS  = 2'd1;
	localparam logic [1:0] CELL_ERA  = 2'd2;
	localparam logic [1:0] CELL_ROT  = 2'd3;

	typedef struct packed {
		logic [2:0]         kind;
		logic [15:0]        position;
		logic signed [31:0] value;
	} pls_in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] element;
		logic [CNT_W-1:0]   count;
		logic               last;
	} pls_out_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic [1:0]         op;
		logic [IDX_W-1:0]   at;
		logic [IDX_W-1:0]   last_idx;
		logic signed [31:0] value;
		logic signed [31:0] head;
	} pls_cmd_t;

endpackage

/* rtl/pls_cell.sv */
// one storage cell of the list row
`timescale 1ns / 1ps
module pls_cell (
	input  logic                      clk,
	input  logic [pls_pkg::IDX_W-1:0] idx,
	input  pls_pkg::pls_cmd_t         cmd,
	input  logic signed [31:0]        left,
	input  logic signed [31:0]        right,
	output logic signed [31:0]        data
);
	import pls_pkg::*;

	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INS: begin
				if (idx > cmd.at) begin
					data_q <= left;
				end else if (idx == cmd.at) begin
					data_q <= cmd.value;
				end
			end
			CELL_ERA: begin
				if (idx >= cmd.at) begin
					data_q <= right;
				end
			end
			CELL_ROT: begin
				if (idx < cmd.last_idx) begin
					data_q <= right;
				end else if (idx == cmd.last_idx) begin
					data_q <= cmd.head;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

/* rtl/positional_list_store.sv */
// positional list store: a row of shifting cells with its request sequencer
// results are registered on rsp, qualified by strobe for one cycle, the cycle after the one that makes them
// push, insert, erase and other kinds: busy stays low, so the block keeps accepting requests
// dump of n elements: busy while its n element beats are made, one element beat per cycle
// the whole row shifts at once, so insert and erase cost no more than a push
// reset: count and sequencer cleared, cell contents left as they are; results cannot stall
`timescale 1ns / 1ps
module positional_list_store (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pls_pkg::pls_in_t  req,
	output logic              strobe,
	output pls_pkg::pls_out_t rsp
);
	import pls_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic                    state_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        dump_idx_q;
	logic                    strobe_q;
	pls_out_t                rsp_q;

	logic                    accept;
	logic                    full;
	logic                    empty;
	logic [IDX_W-1:0]        tail_idx;
	logic [IDX_W-1:0]        end_idx;
	pls_cmd_t                cmd;
	logic signed [31:0]      cell_data [CAPACITY];
	logic                    state_d;
	logic [CNT_W-1:0]        count_d;
	logic                    emit;
	pls_out_t                rsp_d;

	assign accept   = start && !busy;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	// index of the last stored element, only meaningful when not empty
	assign tail_idx = IDX_W'(count_q - CNT_W'(1));
	// index just past the end, only meaningful when not full
	assign end_idx  = IDX_W'(count_q);

	// the row of cells: each one looks at its neighbours, the end cells see zero past the ends
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_lastc
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end
		pls_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(g)),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[g])
		);
	end

	// request decode and dump sequencing
	always_comb begin
		cmd          = '0;
		cmd.op       = CELL_HOLD;
		cmd.value    = req.value;
		cmd.head     = cell_data[0];
		cmd.last_idx = tail_idx;
		state_d      = state_q;
		count_d      = count_q;
		emit         = 1'b0;
		rsp_d        = '0;
		rsp_d.status = STAT_OK;
		rsp_d.last   = 1'b1;
		if (state_q == S_DUMP) begin
			// head goes out, the rest rotate towards the front
			cmd.op        = CELL_ROT;
			emit          = 1'b1;
			rsp_d.element = cell_data[0];
			rsp_d.last    = (dump_idx_q == tail_idx);
			if (dump_idx_q == tail_idx) begin
				state_d = S_IDLE;
			end
		end else if (accept) begin
			emit = 1'b1;
			case (req.kind)
				KIND_PUSH_FRONT, KIND_PUSH_TAIL, KIND_INSERT: begin
					if (full) begin
						rsp_d.status = STAT_FULL;
					end else begin
						cmd.op  = CELL_INS;
						count_d = count_q + CNT_W'(1);
						if (req.kind == KIND_PUSH_FRONT) begin
							cmd.at = '0;
						end else if (req.kind == KIND_PUSH_TAIL) begin
							cmd.at = end_idx;
						end else if (req.position > 16'(count_q)) begin
							// insert past the end appends
							cmd.at       = end_idx;
							rsp_d.status = STAT_APPENDED;
						end else begin
							cmd.at = req.position[IDX_W-1:0];
						end
					end
				end
				KIND_ERASE: begin
					if (empty) begin
						rsp_d.status = STAT_EMPTY;
					end else begin
						cmd.op  = CELL_ERA;
						count_d = count_q - CNT_W'(1);
						if (req.position >= 16'(count_q)) begin
							// erase past the end takes the tail
							cmd.at       = tail_idx;
							rsp_d.status = STAT_TAIL_REMOVED;
						end else begin
							cmd.at = req.position[IDX_W-1:0];
						end
					end
				end
				KIND_DUMP: begin
					if (empty) begin
						rsp_d.status = STAT_EMPTY;
					end else begin
						// beats come from the dump cycles that follow
						emit    = 1'b0;
						state_d = S_DUMP;
					end
				end
				default: begin
				end
			endcase
		end
		rsp_d.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			dump_idx_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= emit;
			if (state_q == S_DUMP) begin
				dump_idx_q <= dump_idx_q + IDX_W'(1);
			end else begin
				dump_idx_q <= '0;
			end
		end
	end

	// result payload needs no reset, the strobe qualifies it
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy   = (state_q == S_DUMP);
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count beyond capacity");

	a_dump_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> (count_q == $past(count_q)))
		else $error("count changed during a dump");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && rsp.status == STAT_FULL) |-> (rsp.count == CNT_W'(CAPACITY)))
		else $error("full status with room left");

	a_dump_enters_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == KIND_DUMP && !empty) |=> busy)
		else $error("dump of a non-empty list did not go busy");

	a_dump_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> strobe)
		else $error("dump cycle gave no beat");
`endif

endmodule

/* verif/pls_checker.sv */
// result checker for the positional list store: watches both channels, predicts and compares
`timescale 1ns / 1ps
module pls_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  pls_pkg::pls_in_t  req,
	input  logic              strobe,
	input  pls_pkg::pls_out_t rsp,
	output int                mismatches,
	output int                outstanding,
	output int                beats_checked
);
	import pls_pkg::*;

	// shadow copy of the list, front at index 0
	logic signed [31:0] shadow_cells [CAPACITY];
	int                 shadow_count;
	pls_out_t           expected_beats [$];
	int                 err_total;
	int                 beat_total;

	task automatic queue_beat(input logic [2:0] st, input logic signed [31:0] elem,
			input logic fin);
		pls_out_t b;
		b.status  = st;
		b.element = elem;
		b.count   = CNT_W'(shadow_count);
		b.last    = fin;
		expected_beats = {expected_beats, b};
	endtask

	// apply one accepted request to the shadow list and queue its beats
	task automatic predict_request(input pls_in_t r);
		int         i;
		int         at;
		logic [2:0] st;
		st = STAT_OK;
		at = 0;
		case (r.kind)
			KIND_PUSH_FRONT, KIND_PUSH_TAIL, KIND_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					st = STAT_FULL;
				end else begin
					if (r.kind == KIND_PUSH_FRONT)
						at = 0;
					else if (r.kind == KIND_PUSH_TAIL)
						at = shadow_count;
					else if (int'(r.position) > shadow_count) begin
						at = shadow_count;
						st = STAT_APPENDED;
					end else
						at = int'(r.position);
					for (i = shadow_count; i > at; i--)
						shadow_cells[i] = shadow_cells[i-1];
					shadow_cells[at] = r.value;
					shadow_count++;
				end
			end
			KIND_ERASE: begin
				if (shadow_count == 0) begin
					st = STAT_EMPTY;
				end else begin
					if (int'(r.position) >= shadow_count) begin
						at = shadow_count - 1;
						st = STAT_TAIL_REMOVED;
					end else
						at = int'(r.position);
					for (i = at; i + 1 < shadow_count; i++)
						shadow_cells[i] = shadow_cells[i+1];
					shadow_count--;
				end
			end
			KIND_DUMP: begin
				if (shadow_count == 0)
					queue_beat(STAT_EMPTY, '0, 1'b1);
				else
					for (i = 0; i < shadow_count; i++)
						queue_beat(STAT_OK, shadow_cells[i], i == shadow_count - 1);
			end
			default: ;
		endcase
		if (r.kind != KIND_DUMP)
			queue_beat(st, '0, 1'b1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pls_out_t want;
		if (!arst_n) begin
			expected_beats.delete();
			shadow_count = 0;
			err_total    = 0;
			beat_total   = 0;
		end else begin
			// a beat on this edge belongs to a request accepted on an earlier edge
			if (strobe) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected result beat: status %0d element %0d count %0d last %0d",
						rsp.status, rsp.element, rsp.count, rsp.last);
					err_total++;
				end else begin
					want = expected_beats.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						err_total++;
					end
					if (rsp.element !== want.element) begin
						$error("element: expected %0d, got %0d", want.element, rsp.element);
						err_total++;
					end
					if (rsp.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp.count);
						err_total++;
					end
					if (rsp.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, rsp.last);
						err_total++;
					end
					beat_total++;
				end
			end
			if (start && !busy)
				predict_request(req);
		end
		mismatches    <= err_total;
		outstanding   <= expected_beats.size();
		beats_checked <= beat_total;
	end

endmodule

/* verif/positional_list_store_tb.sv */
// testbench top for the positional list store: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module positional_list_store_tb;
	import pls_pkg::*;

	// kinds the block does not decode; they must leave the list alone
	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
	localparam int         RANDOM_ITEMS     = 145;
	localparam int         PHASE_LEN        = 24;
	// longest honest silence is the longest sender gap; allow far more
	localparam int         WATCHDOG_LIMIT   = 200;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	logic     busy;
	pls_in_t  req    = '0;
	logic     strobe;
	pls_out_t rsp;

	int  mismatches;
	int  outstanding;
	int  beats_checked;
	int  quiet_cycles = 0;
	int  sent_by_kind [8];
	bit  gaps_on = 1'b1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	positional_list_store dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.rsp    (rsp)
	);

	pls_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.strobe        (strobe),
		.rsp           (rsp),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.beats_checked (beats_checked)
	);

	// watchdog: any accepted request or result beat counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic pls_in_t make_req(input logic [2:0] k, input logic [15:0] pos,
			input logic signed [31:0] val);
		pls_in_t r;
		r.kind     = k;
		r.position = pos;
		r.value    = val;
		return r;
	endfunction

	// offer one request and hold it until the block takes it; start only
	// drops when a gap follows, so it never toggles within one step
	task automatic send_req(input pls_in_t r);
		if (gaps_on && $urandom_range(0, 99) < 16) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent_by_kind[r.kind]++;
	endtask

	// random request; fill phases lean on push and insert so the store
	// reaches full, drain phases lean on erase so it empties again
	function automatic pls_in_t random_req(input bit filling);
		int          roll;
		logic [2:0]  k;
		logic [15:0] pos;
		roll = $urandom_range(0, 99);
		if (roll < 9)
			k = KIND_DUMP;
		else if (roll < 12)
			k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
		else if (roll < (filling ? 82 : 37)) begin
			case ($urandom_range(0, 2))
				0:       k = KIND_PUSH_FRONT;
				1:       k = KIND_PUSH_TAIL;
				default: k = KIND_INSERT;
			endcase
		end else
			k = KIND_ERASE;
		// mostly positions near the live range, now and then anywhere in the field
		if ($urandom_range(0, 99) < 70)
			pos = 16'($urandom_range(0, CAPACITY + 1));
		else
			pos = 16'($urandom_range(0, 65535));
		return make_req(k, pos, $urandom);
	endfunction

	initial begin
		int i;
		int spare_sent;
		foreach (sent_by_kind[i])
			sent_by_kind[i] = 0;
		spare_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store corner cases first
		send_req(make_req(KIND_DUMP, 16'h0000, 32'sd0));
		send_req(make_req(KIND_ERASE, 16'h0000, 32'sd0));
		send_req(make_req(KIND_INSERT, 16'hFFFF, 32'h8000_0000));
		send_req(make_req(KIND_INSERT, 16'h0000, 32'h7FFF_FFFF));
		// insert at exactly the count appends cleanly
		send_req(make_req(KIND_INSERT, 16'h0002, 32'hFFFF_FFFF));
		// fill to capacity from both ends and the middle
		for (i = 3; i < CAPACITY; i++) begin
			case (i % 3)
				0:       send_req(make_req(KIND_PUSH_FRONT, 16'hAAAA, 32'($urandom)));
				1:       send_req(make_req(KIND_PUSH_TAIL, 16'h5555, 32'($urandom)));
				default: send_req(make_req(KIND_INSERT, 16'(i / 2), 32'($urandom)));
			endcase
		end
		// full store rejects, then a dump of every cell
		send_req(make_req(KIND_PUSH_FRONT, 16'h0000, 32'h1234_5678));
		send_req(make_req(KIND_INSERT, 16'hFFFF, 32'h8765_4321));
		send_req(make_req(KIND_DUMP, 16'hFFFF, 32'hFFFF_FFFF));
		// erase past the end, at the front and in the middle
		send_req(make_req(KIND_ERASE, 16'hFFFF, 32'sd0));
		send_req(make_req(KIND_ERASE, 16'h0000, 32'sd0));
		send_req(make_req(KIND_ERASE, 16'h0005, 32'hFFFF_FFFF));
		send_req(make_req(KIND_SPARE_FIRST, 16'h0001, 32'h0F0F_0F0F));

		// random part, with a long stretch of back-to-back beats in the middle
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			gaps_on = !(i >= 60 && i < 100);
			send_req(random_req((i / PHASE_LEN) % 2 == 0));
		end
		start <= 1'b0;

		// let the outstanding count take in the last request first
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		// results are registered after they are made; keep watching for strays
		repeat (4) @(posedge clk);

		for (i = KIND_SPARE_FIRST; i <= KIND_SPARE_LAST; i++)
			spare_sent += sent_by_kind[i];
		$display("covered %0d pushes, %0d inserts, %0d erases, %0d dumps, %0d spare kinds",
			sent_by_kind[KIND_PUSH_FRONT] + sent_by_kind[KIND_PUSH_TAIL],
			sent_by_kind[KIND_INSERT], sent_by_kind[KIND_ERASE], sent_by_kind[KIND_DUMP],
			spare_sent);
		$display("%0d result beats compared, %0d mismatches", beats_checked, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
